[src/hfs_pkg.sv]
// Shared types, constants and codes for the hierarchical float sum block.
`timescale 1ns / 1ps
package hfs_pkg;

  localparam int LANES_DEF  = 4;
  localparam int LEVELS_DEF = 12;
  localparam int BLOCK_DEF  = 8;

  // Number of lanes carried by the item fields
  localparam int FIELD_LANES = 4;

  localparam int CW = 4;
  localparam logic [CW-1:0] COUNT_MAX = 4'd15;

  // Wide enough for any level index in the parameter range
  localparam int AW_MAX = 4;

  localparam logic [1:0] ACT_CLEAR = 2'd0;
  localparam logic [1:0] ACT_ADD   = 2'd1;
  localparam logic [1:0] ACT_READ  = 2'd2;

  localparam logic [63:0] DEFAULT_NAN = 64'hFFF8_0000_0000_0000;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ADD_RD,
    ST_ADD_GO,
    ST_WAIT,
    ST_CHECK,
    ST_CR1,
    ST_CR2,
    ST_CR_GO,
    ST_RD_INIT,
    ST_RD_NEXT,
    ST_RD_B,
    ST_RD_GO,
    ST_RD_OUT
  } seq_state_t;

  // Per-cycle commands from the sequencer to every lane
  typedef struct packed {
    logic              clr;
    logic              lat_a;
    logic              lat_a_acc;
    logic              lat_b;
    logic              lat_bv;
    logic              lat_acc;
    logic              start;
    logic              wr_mem;
    logic              inv;
    logic [AW_MAX-1:0] rd_addr;
    logic [AW_MAX-1:0] wr_addr;
    logic [AW_MAX-1:0] inv_addr;
  } lane_ctrl_t;

endpackage

[src/hfs_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module hfs_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 12
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[src/hfs_fadd.sv]
// Five-stage IEEE double adder, round to nearest even.
`timescale 1ns / 1ps
module hfs_fadd
  import hfs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic        done,
  output logic [63:0] res
);

  function automatic logic [5:0] lead_zeros(input logic [55:0] s);
    logic [5:0] n;
    n = 6'd56;
    for (int i = 0; i < 56; i++) begin
      if (s[i]) begin
        n = 6'(55 - i);
      end
    end
    return n;
  endfunction

  logic [4:0] vld;

  // Stage 1: unpack, specials, order by magnitude, align
  logic        sa, sb, a_nan, b_nan, a_inf, b_inf, a_big;
  logic [10:0] ea, eb, el, es, d;
  logic [52:0] ma, mb, ml, msm;
  logic [5:0]  dc;
  logic [119:0] sh;
  logic        spec_c;
  logic [63:0] spec_val_c;

  assign sa = a[63];
  assign sb = b[63];
  assign a_nan = (a[62:52] == 11'h7FF) && (a[51:0] != 52'd0);
  assign b_nan = (b[62:52] == 11'h7FF) && (b[51:0] != 52'd0);
  assign a_inf = (a[62:52] == 11'h7FF) && (a[51:0] == 52'd0);
  assign b_inf = (b[62:52] == 11'h7FF) && (b[51:0] == 52'd0);
  assign ea = (a[62:52] == 11'd0) ? 11'd1 : a[62:52];
  assign eb = (b[62:52] == 11'd0) ? 11'd1 : b[62:52];
  assign ma = {a[62:52] != 11'd0, a[51:0]};
  assign mb = {b[62:52] != 11'd0, b[51:0]};
  assign a_big = {ea, ma} >= {eb, mb};
  assign el  = a_big ? ea : eb;
  assign es  = a_big ? eb : ea;
  assign ml  = a_big ? ma : mb;
  assign msm = a_big ? mb : ma;
  assign d   = el - es;
  assign dc  = (d > 11'd63) ? 6'd63 : d[5:0];
  assign sh  = {msm, 3'b000, 64'd0} >> dc;

  always_comb begin
    spec_c = 1'b1;
    spec_val_c = 64'd0;
    if (a_nan) begin
      spec_val_c = a | 64'h0008_0000_0000_0000;
    end else if (b_nan) begin
      spec_val_c = b | 64'h0008_0000_0000_0000;
    end else if (a_inf && b_inf && (sa != sb)) begin
      spec_val_c = DEFAULT_NAN;
    end else if (a_inf) begin
      spec_val_c = a;
    end else if (b_inf) begin
      spec_val_c = b;
    end else begin
      spec_c = 1'b0;
    end
  end

  logic        s1_sign, s1_sub, s1_zs, s1_spec;
  logic [63:0] s1_sval;
  logic [11:0] s1_e;
  logic [55:0] s1_ml, s1_ms;

  always_ff @(posedge clk) begin
    if (start) begin
      s1_sign <= a_big ? sa : sb;
      s1_sub  <= sa ^ sb;
      s1_zs   <= sa & sb;
      s1_spec <= spec_c;
      s1_sval <= spec_val_c;
      s1_e    <= {1'b0, el};
      s1_ml   <= {ml, 3'b000};
      s1_ms   <= sh[119:64] | {55'd0, |sh[63:0]};
    end
  end

  // Stage 2: add or subtract magnitudes
  logic        s2_sign, s2_zs, s2_spec;
  logic [63:0] s2_sval;
  logic [11:0] s2_e;
  logic [56:0] s2_sum;

  always_ff @(posedge clk) begin
    s2_sign <= s1_sign;
    s2_zs   <= s1_zs;
    s2_spec <= s1_spec;
    s2_sval <= s1_sval;
    s2_e    <= s1_e;
    s2_sum  <= s1_sub ? ({1'b0, s1_ml} - {1'b0, s1_ms}) : ({1'b0, s1_ml} + {1'b0, s1_ms});
  end

  // Stage 3: count leading zeros
  logic        s3_sign, s3_zs, s3_spec;
  logic [63:0] s3_sval;
  logic [11:0] s3_e;
  logic [56:0] s3_sum;
  logic [5:0]  s3_lz;

  always_ff @(posedge clk) begin
    s3_sign <= s2_sign;
    s3_zs   <= s2_zs;
    s3_spec <= s2_spec;
    s3_sval <= s2_sval;
    s3_e    <= s2_e;
    s3_sum  <= s2_sum;
    s3_lz   <= lead_zeros(s2_sum[55:0]);
  end

  // Stage 4: normalize, stopping at the subnormal range
  logic [11:0] emax_sh, nsh;

  assign emax_sh = s3_e - 12'd1;
  assign nsh = ({6'd0, s3_lz} < emax_sh) ? {6'd0, s3_lz} : emax_sh;

  logic        s4_sign, s4_zs, s4_spec, s4_zero;
  logic [63:0] s4_sval;
  logic [11:0] s4_e;
  logic [55:0] s4_m;

  always_ff @(posedge clk) begin
    s4_sign <= s3_sign;
    s4_zs   <= s3_zs;
    s4_spec <= s3_spec;
    s4_sval <= s3_sval;
    s4_zero <= (s3_sum == 57'd0);
    if (s3_sum[56]) begin
      s4_m <= s3_sum[56:1] | {55'd0, s3_sum[0]};
      s4_e <= s3_e + 12'd1;
    end else begin
      s4_m <= s3_sum[55:0] << nsh[5:0];
      s4_e <= s3_e - nsh;
    end
  end

  // Stage 5: round and pack
  logic        inc;
  logic [53:0] rnd;
  logic [52:0] mant;
  logic [11:0] e2;

  assign inc  = s4_m[2] & (s4_m[1] | s4_m[0] | s4_m[3]);
  assign rnd  = {1'b0, s4_m[55:3]} + {53'd0, inc};
  assign mant = rnd[53] ? rnd[53:1] : rnd[52:0];
  assign e2   = rnd[53] ? (s4_e + 12'd1) : s4_e;

  always_ff @(posedge clk) begin
    if (s4_spec) begin
      res <= s4_sval;
    end else if (s4_zero) begin
      res <= {s4_zs, 63'd0};
    end else if (e2 >= 12'd2047) begin
      res <= {s4_sign, 11'h7FF, 52'd0};
    end else begin
      res <= {s4_sign, mant[52] ? e2[10:0] : 11'd0, mant[51:0]};
    end
  end

  // Advance the stage valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[3:0], start};
    end
  end

  assign done = vld[4];

endmodule

[src/hfs_lane.sv]
// One lane: level sums in a RAM, operand registers, adder and read total.
`timescale 1ns / 1ps
module hfs_lane
  import hfs_pkg::*;
#(
  parameter int LEVELS = LEVELS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  lane_ctrl_t  ctrl,
  input  logic [63:0] value,
  output logic        done,
  output logic [63:0] acc
);

  localparam int LW = $clog2(LEVELS);

  logic [LEVELS-1:0] valid;
  logic              rd_v;
  logic [63:0]       rdata, rd_word, opa, opb, res;
  logic              wr_mem_q;
  logic [LW-1:0]     wr_addr_q;
  logic              we;

  assign we = done & wr_mem_q;

  hfs_ram #(.WIDTH(64), .DEPTH(LEVELS)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (wr_addr_q),
    .wdata (res),
    .raddr (ctrl.rd_addr[LW-1:0]),
    .rdata (rdata)
  );

  // An entry never written since clear, or invalidated by a carry, reads as +0.0
  assign rd_word = rd_v ? rdata : 64'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      rd_v  <= 1'b0;
    end else begin
      rd_v <= valid[ctrl.rd_addr[LW-1:0]];
      if (ctrl.clr) begin
        valid <= '0;
      end else begin
        if (ctrl.inv) begin
          valid[ctrl.inv_addr[LW-1:0]] <= 1'b0;
        end
        if (we) begin
          valid[wr_addr_q] <= 1'b1;
        end
      end
    end
  end

  // Load operands and the read total, and hold the write target for the running add
  always_ff @(posedge clk) begin
    if (ctrl.lat_a) begin
      opa <= rd_word;
    end else if (ctrl.lat_a_acc) begin
      opa <= acc;
    end
    if (ctrl.lat_b) begin
      opb <= rd_word;
    end else if (ctrl.lat_bv) begin
      opb <= value;
    end
    if (ctrl.start) begin
      wr_mem_q  <= ctrl.wr_mem;
      wr_addr_q <= ctrl.wr_addr[LW-1:0];
    end
    if (ctrl.lat_acc) begin
      acc <= rd_word;
    end else if (done && !wr_mem_q) begin
      acc <= res;
    end
  end

  hfs_fadd u_fadd (
    .clk   (clk),
    .rst   (rst),
    .start (ctrl.start),
    .a     (opa),
    .b     (opb),
    .done  (done),
    .res   (res)
  );

endmodule

[src/hfs_seq.sv]
// Sequencer: level counts, carry cascade and read accumulation order.
`timescale 1ns / 1ps
module hfs_seq
  import hfs_pkg::*;
#(
  parameter int LEVELS = LEVELS_DEF,
  parameter int BLOCK  = BLOCK_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [1:0] action,
  input  logic       done,
  input  logic       out_free,
  output logic       in_stall,
  output lane_ctrl_t ctrl,
  output logic       out_load
);

  localparam int LW = $clog2(LEVELS);
  localparam int IW = $clog2(LEVELS + 1);
  localparam logic [IW-1:0] LAST = IW'(LEVELS);

  seq_state_t state, state_next;
  logic [IW-1:0] idx, idx_next;
  logic          ret_read, ret_read_next;
  logic [CW-1:0] cnt [LEVELS];
  logic [IW-1:0] im1;
  logic          acc_in;

  assign im1      = idx - IW'(1);
  assign in_stall = (state != ST_IDLE);
  assign acc_in   = in_valid && (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      idx      <= '0;
      ret_read <= 1'b0;
    end else begin
      state    <= state_next;
      idx      <= idx_next;
      ret_read <= ret_read_next;
    end
  end

  // Next state and lane commands
  always_comb begin
    state_next    = state;
    idx_next      = idx;
    ret_read_next = ret_read;
    ctrl          = '0;
    out_load      = 1'b0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          case (action)
            ACT_CLEAR: ctrl.clr = 1'b1;
            ACT_ADD:   state_next = ST_ADD_RD;
            ACT_READ:  state_next = ST_RD_INIT;
            default:   state_next = ST_IDLE;
          endcase
        end
      end
      ST_ADD_RD: begin
        ctrl.lat_a  = 1'b1;
        ctrl.lat_bv = 1'b1;
        state_next  = ST_ADD_GO;
      end
      ST_ADD_GO: begin
        ctrl.start    = 1'b1;
        ctrl.wr_mem   = 1'b1;
        idx_next      = IW'(1);
        ret_read_next = 1'b0;
        state_next    = ST_WAIT;
      end
      ST_WAIT: begin
        if (done) begin
          state_next = ret_read ? ST_RD_NEXT : ST_CHECK;
        end
      end
      ST_CHECK: begin
        if ((idx < LAST) && (cnt[im1[LW-1:0]] >= CW'(BLOCK))) begin
          ctrl.rd_addr = AW_MAX'(im1);
          state_next   = ST_CR1;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_CR1: begin
        ctrl.lat_b   = 1'b1;
        ctrl.rd_addr = AW_MAX'(idx);
        state_next   = ST_CR2;
      end
      ST_CR2: begin
        ctrl.lat_a = 1'b1;
        state_next = ST_CR_GO;
      end
      ST_CR_GO: begin
        ctrl.start    = 1'b1;
        ctrl.wr_mem   = 1'b1;
        ctrl.wr_addr  = AW_MAX'(idx);
        ctrl.inv      = 1'b1;
        ctrl.inv_addr = AW_MAX'(im1);
        idx_next      = idx + IW'(1);
        state_next    = ST_WAIT;
      end
      ST_RD_INIT: begin
        ctrl.lat_acc = 1'b1;
        idx_next     = IW'(1);
        state_next   = ST_RD_NEXT;
      end
      ST_RD_NEXT: begin
        if (idx == LAST) begin
          state_next = ST_RD_OUT;
        end else if (cnt[idx[LW-1:0]] != '0) begin
          ctrl.rd_addr = AW_MAX'(idx);
          state_next   = ST_RD_B;
        end else begin
          idx_next = idx + IW'(1);
        end
      end
      ST_RD_B: begin
        ctrl.lat_b     = 1'b1;
        ctrl.lat_a_acc = 1'b1;
        state_next     = ST_RD_GO;
      end
      ST_RD_GO: begin
        ctrl.start    = 1'b1;
        idx_next      = idx + IW'(1);
        ret_read_next = 1'b1;
        state_next    = ST_WAIT;
      end
      ST_RD_OUT: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Update level counts: clear, count an add, move a carry up
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LEVELS; i++) begin
        cnt[i] <= '0;
      end
    end else if (acc_in && (action == ACT_CLEAR)) begin
      for (int i = 0; i < LEVELS; i++) begin
        cnt[i] <= '0;
      end
    end else if (state == ST_ADD_GO) begin
      if (cnt[0] != COUNT_MAX) begin
        cnt[0] <= cnt[0] + CW'(1);
      end
    end else if (state == ST_CR_GO) begin
      cnt[im1[LW-1:0]] <= '0;
      if (cnt[idx[LW-1:0]] != COUNT_MAX) begin
        cnt[idx[LW-1:0]] <= cnt[idx[LW-1:0]] + CW'(1);
      end
    end
  end

endmodule

[src/hierarchical_float_sum_core.sv]
// Top level of the hierarchical double-precision sum block.
//
//  channel | handshake            | payload
//  --------+----------------------+------------------------------
//  input   | in_valid / in_stall  | action, value_0 .. value_3
//  output  | out_valid / out_stall| sum_0 .. sum_3
//
// One item at a time; each double add runs in every lane's adder.
// A clear item leaves the block idle; an add item carries each full level
// up into the next one, and a read item adds every higher level with a nonzero count.
// Reset clears all counts and the lane valid bits.
// A read result waits in the output register while out_stall is high;
// new items are still taken, and a further read holds until it is free.
`timescale 1ns / 1ps
module hierarchical_float_sum_core
  import hfs_pkg::*;
#(
  parameter int LANES  = LANES_DEF,
  parameter int LEVELS = LEVELS_DEF,
  parameter int BLOCK  = BLOCK_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  action,
  input  logic [63:0] value_0,
  input  logic [63:0] value_1,
  input  logic [63:0] value_2,
  input  logic [63:0] value_3,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] sum_0,
  output logic [63:0] sum_1,
  output logic [63:0] sum_2,
  output logic [63:0] sum_3
);

  lane_ctrl_t  ctrl;
  logic        out_load, out_free;
  logic [LANES-1:0] done_v;
  logic [63:0] val_q [FIELD_LANES];
  logic [63:0] acc_v [LANES];
  logic [63:0] fld [FIELD_LANES];

  assign fld[0] = value_0;
  assign fld[1] = value_1;
  assign fld[2] = value_2;
  assign fld[3] = value_3;

  // Hold the values of an accepted item
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      for (int j = 0; j < FIELD_LANES; j++) begin
        val_q[j] <= fld[j];
      end
    end
  end

  assign out_free = !out_valid || !out_stall;

  hfs_seq #(.LEVELS(LEVELS), .BLOCK(BLOCK)) u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .action   (action),
    .done     (&done_v),
    .out_free (out_free),
    .in_stall (in_stall),
    .ctrl     (ctrl),
    .out_load (out_load)
  );

  for (genvar j = 0; j < LANES; j++) begin : g_lane
    logic [63:0] lane_val;
    if (j < FIELD_LANES) begin : g_fed
      assign lane_val = val_q[j];
    end else begin : g_zero
      assign lane_val = 64'd0;
    end
    hfs_lane #(.LEVELS(LEVELS)) u_lane (
      .clk   (clk),
      .rst   (rst),
      .ctrl  (ctrl),
      .value (lane_val),
      .done  (done_v[j]),
      .acc   (acc_v[j])
    );
  end

  // Merge lane totals into the output register
  logic [63:0] merged [FIELD_LANES];

  always_comb begin
    for (int j = 0; j < FIELD_LANES; j++) begin
      merged[j] = (j < LANES) ? acc_v[j % LANES] : 64'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      sum_0 <= merged[0];
      sum_1 <= merged[1];
      sum_2 <= merged[2];
      sum_3 <= merged[3];
    end
  end

endmodule

[src/hfs_checker.sv]
// Port-level assertions for the hierarchical float sum block, with bind.
`timescale 1ns / 1ps
module hfs_checker
  import hfs_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic [1:0]  action,
  input logic        out_valid,
  input logic        out_stall,
  input logic [63:0] sum_0
);

  // Leave reset idle with nothing to deliver
  a_reset_idle: assert property (@(posedge clk) rst |=> !in_stall && !out_valid)
    else $error("block not idle after reset");

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(sum_0))
    else $error("stalled result changed");

  // An add item keeps the block busy afterward
  a_add_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && (action == ACT_ADD) |=> in_stall)
    else $error("add item did not occupy the block");

  // A clear item leaves the block free for the next item
  a_clear_fast: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && (action == ACT_CLEAR) |=> !in_stall)
    else $error("clear item stalled the block");

endmodule

bind hierarchical_float_sum_core hfs_checker u_hfs_checker (.*);
